[rtl/core/lbp_pkg.sv]
// Shared types, constants and the pattern function of the 3x3 LBP pixel stream.
// Used by the channel interfaces and the top level; no dependencies.
package lbp_pkg;

    // Image geometry limits and field widths.
    localparam int MAX_WIDTH   = 2048;
    localparam int MAX_HEIGHT  = 2048;
    localparam int PIX_W       = 8;
    localparam int CODE_W      = 8;
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int ROW_W       = $clog2(MAX_HEIGHT);
    localparam int CFG_W       = 12;
    localparam int CFG_IDX_W   = 1;
    localparam int MAX_RESULTS = 4;
    localparam int RES_IDX_W   = $clog2(MAX_RESULTS);
    localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);
    localparam int LINE_W      = 2 * PIX_W;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'd1;

    // Reset values of the configuration registers.
    localparam logic [CFG_W-1:0] RST_IMAGE_WIDTH  = 12'd64;
    localparam logic [CFG_W-1:0] RST_IMAGE_HEIGHT = 12'd48;

    // Neighbor weights.
    localparam logic [CODE_W-1:0] WT_TOP_LEFT     = 8'd64;
    localparam logic [CODE_W-1:0] WT_LEFT         = 8'd32;
    localparam logic [CODE_W-1:0] WT_BOTTOM_LEFT  = 8'd16;
    localparam logic [CODE_W-1:0] WT_TOP          = 8'd128;
    localparam logic [CODE_W-1:0] WT_BOTTOM       = 8'd8;
    localparam logic [CODE_W-1:0] WT_TOP_RIGHT    = 8'd1;
    localparam logic [CODE_W-1:0] WT_RIGHT        = 8'd2;
    localparam logic [CODE_W-1:0] WT_BOTTOM_RIGHT = 8'd4;

    // Window row and column positions, oldest first.
    localparam logic [1:0] IDX_OLD = 2'd0;
    localparam logic [1:0] IDX_MID = 2'd1;
    localparam logic [1:0] IDX_NEW = 2'd2;

    // 3x3 window: [row][column] of pixels.
    typedef logic [2:0][2:0][PIX_W-1:0] win_t;

    // One pending result before the last-of-run flag is attached.
    typedef struct packed {
        logic [CODE_W-1:0] lbp_code;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
    } slot_t;

    // Pattern code of the window with the given row and column selections.
    function automatic logic [CODE_W-1:0] lbp_pattern(
        input win_t       w,
        input logic [1:0] t,
        input logic [1:0] m,
        input logic [1:0] b,
        input logic [1:0] l,
        input logic [1:0] c,
        input logic [1:0] r
    );
        logic [PIX_W-1:0]  ctr;
        logic [CODE_W-1:0] code;
        ctr  = w[m][c];
        code = '0;
        if (w[t][l] >= ctr) code = code | WT_TOP_LEFT;
        if (w[m][l] >= ctr) code = code | WT_LEFT;
        if (w[b][l] >= ctr) code = code | WT_BOTTOM_LEFT;
        if (w[t][c] >= ctr) code = code | WT_TOP;
        if (w[b][c] >= ctr) code = code | WT_BOTTOM;
        if (w[t][r] >= ctr) code = code | WT_TOP_RIGHT;
        if (w[m][r] >= ctr) code = code | WT_RIGHT;
        if (w[b][r] >= ctr) code = code | WT_BOTTOM_RIGHT;
        return code;
    endfunction

endpackage

[rtl/core/lbp_pix_if.sv]
// Pixel input channel: valid/ready handshake carrying one grey pixel.
// Depends on lbp_pkg for the pixel width.
interface lbp_pix_if import lbp_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel;

    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface

[rtl/core/lbp_res_if.sv]
// Result output channel: valid/ready handshake carrying one LBP code and its position.
// Depends on lbp_pkg for the field widths.
interface lbp_res_if import lbp_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CODE_W-1:0] lbp_code;
    logic [ROW_W-1:0]  out_row;
    logic [COL_W-1:0]  out_col;
    logic              last_of_run;

    modport source (output valid, output lbp_code, output out_row, output out_col,
                    output last_of_run, input ready);
    modport sink   (input valid, input lbp_code, input out_row, input out_col,
                    input last_of_run, output ready);
endinterface

[rtl/core/lbp_3x3_pixel_stream.sv]
// Top level of the 3x3 local binary pattern pixel stream.
// Depends on lbp_pkg, lbp_pix_if, lbp_res_if and lbp_ram.

// The block takes pixels in raster order and returns, for each pixel, its 3x3 LBP code
// with its row and column, edges replicated. A pixel passes a line-buffer read stage and
// then a compare stage that loads the output result register. The output register drains
// one code per cycle while the receiver is ready: a pixel that releases n codes (up to four
// at a row end or on the last row) holds the output until all n are taken, and the pixel
// stream sustains one pixel per cycle whenever each pixel releases at most one code and the
// receiver is ready. The two line buffers sit in one 2048 x 16 memory with one write and
// one read port; no clearing pass is needed after reset.
module lbp_3x3_pixel_stream import lbp_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    lbp_pix_if.sink              pix_in,
    lbp_res_if.source            res_out
);

    // Configuration registers.
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;

    // Position counters of the next pixel.
    logic [COL_W-1:0] col_cnt_reg, col_cnt_next;
    logic [ROW_W-1:0] row_cnt_reg, row_cnt_next;
    logic [COL_W-1:0] last_col;
    logic [ROW_W-1:0] last_rowidx;
    logic             row_end;
    logic             last_row;

    // Read stage.
    logic             s1_valid_reg;
    logic [PIX_W-1:0] s1_pixel_reg;
    logic [COL_W-1:0] s1_col_reg;
    logic [ROW_W-1:0] s1_row_reg;
    logic             s1_row_end_reg;
    logic             s1_last_row_reg;
    logic             fwd_valid_reg, fwd_valid_next;
    logic [LINE_W-1:0] fwd_data_reg;
    logic [LINE_W-1:0] ram_rd_data;
    logic [LINE_W-1:0] line_data;
    logic [LINE_W-1:0] line_wr_data;

    // Window and compare stage.
    win_t             win_reg, win_next;
    slot_t [MAX_RESULTS-1:0] cand;
    logic  [MAX_RESULTS-1:0] cand_en;
    slot_t [MAX_RESULTS-1:0] slot_next;
    logic  [RES_CNT_W-1:0]   slot_cnt;
    logic  [1:0] top_prev, top_cur, left_prev, left_cur;

    // Result register.
    slot_t [MAX_RESULTS-1:0] slot_reg;
    logic  [RES_CNT_W-1:0]   res_left_reg, res_left_next;
    logic  [RES_IDX_W-1:0]   res_ptr_reg, res_ptr_next;

    // Handshake.
    logic in_fire;
    logic out_fire;
    logic res_free;
    logic s1_adv;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= RST_IMAGE_WIDTH;
            height_reg <= RST_IMAGE_HEIGHT;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_IMAGE_WIDTH:  width_reg  <= cfg_data;
                CFG_IMAGE_HEIGHT: height_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    // Last column and row index: zero is taken as one, large values saturate.
    always_comb
    begin
        if (width_reg == '0)
            last_col = '0;
        else if (width_reg > CFG_W'(MAX_WIDTH))
            last_col = COL_W'(MAX_WIDTH - 1);
        else
            last_col = COL_W'(width_reg - 1'b1);

        if (height_reg == '0)
            last_rowidx = '0;
        else if (height_reg > CFG_W'(MAX_HEIGHT))
            last_rowidx = ROW_W'(MAX_HEIGHT - 1);
        else
            last_rowidx = ROW_W'(height_reg - 1'b1);
    end

    // Handshake control: the read stage moves on whenever the result register frees up.
    assign res_free     = (res_left_reg == '0) || (res_out.ready && res_left_reg == RES_CNT_W'(1));
    assign s1_adv       = s1_valid_reg && res_free;
    assign pix_in.ready = !s1_valid_reg || res_free;
    assign in_fire      = pix_in.valid && pix_in.ready;
    assign out_fire     = res_out.valid && res_out.ready;

    // Position of the next pixel.
    assign row_end  = (col_cnt_reg >= last_col);
    assign last_row = (row_cnt_reg >= last_rowidx);

    always_comb
    begin
        col_cnt_next = col_cnt_reg;
        row_cnt_next = row_cnt_reg;
        if (in_fire)
        begin
            if (row_end)
            begin
                col_cnt_next = '0;
                row_cnt_next = last_row ? '0 : row_cnt_reg + 1'b1;
            end
            else
            begin
                col_cnt_next = col_cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_cnt_reg <= '0;
            row_cnt_reg <= '0;
        end
        else
        begin
            col_cnt_reg <= col_cnt_next;
            row_cnt_reg <= row_cnt_next;
        end
    end

    // Line buffers: {two rows back, one row back} per column.
    lbp_ram #(
        .WIDTH (LINE_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .clk     (clk),
        .wr_en   (s1_adv),
        .wr_addr (s1_col_reg),
        .wr_data (line_wr_data),
        .rd_en   (in_fire),
        .rd_addr (col_cnt_reg),
        .rd_data (ram_rd_data)
    );

    // A read of the column written in the same cycle takes the written data instead.
    // The forwarded data is dropped once its pixel leaves the read stage.
    assign line_data    = fwd_valid_reg ? fwd_data_reg : ram_rd_data;
    assign line_wr_data = {line_data[PIX_W-1:0], s1_pixel_reg};
    assign fwd_valid_next = in_fire ? (s1_adv && (s1_col_reg == col_cnt_reg))
                                    : (fwd_valid_reg && !s1_adv);

    // Read stage registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= in_fire || (s1_valid_reg && !s1_adv);
            fwd_valid_reg <= fwd_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_pixel_reg    <= pix_in.pixel;
            s1_col_reg      <= col_cnt_reg;
            s1_row_reg      <= row_cnt_reg;
            s1_row_end_reg  <= row_end;
            s1_last_row_reg <= last_row;
            fwd_data_reg    <= line_wr_data;
        end
    end

    // New window: shift left by one column and insert the incoming column.
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            win_next[k][IDX_OLD] = win_reg[k][IDX_MID];
            win_next[k][IDX_MID] = win_reg[k][IDX_NEW];
        end
        win_next[IDX_OLD][IDX_NEW] = line_data[LINE_W-1:PIX_W];
        win_next[IDX_MID][IDX_NEW] = line_data[PIX_W-1:0];
        win_next[IDX_NEW][IDX_NEW] = s1_pixel_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            win_reg <= '0;
        else if (s1_adv)
            win_reg <= win_next;
    end

    // Edge replication picks the nearest row or column inside the image.
    assign top_prev  = (s1_row_reg == ROW_W'(1)) ? IDX_MID : IDX_OLD;
    assign top_cur   = (s1_row_reg == '0)        ? IDX_NEW : IDX_MID;
    assign left_prev = (s1_col_reg == COL_W'(1)) ? IDX_MID : IDX_OLD;
    assign left_cur  = (s1_col_reg == '0)        ? IDX_NEW : IDX_MID;

    // Four candidate codes, previous row before current row, left column before row end.
    always_comb
    begin
        cand[0].lbp_code = lbp_pattern(win_next, top_prev, IDX_MID, IDX_NEW,
                                       left_prev, IDX_MID, IDX_NEW);
        cand[0].row      = s1_row_reg - 1'b1;
        cand[0].col      = s1_col_reg - 1'b1;
        cand[1].lbp_code = lbp_pattern(win_next, top_prev, IDX_MID, IDX_NEW,
                                       left_cur, IDX_NEW, IDX_NEW);
        cand[1].row      = s1_row_reg - 1'b1;
        cand[1].col      = s1_col_reg;
        cand[2].lbp_code = lbp_pattern(win_next, top_cur, IDX_NEW, IDX_NEW,
                                       left_prev, IDX_MID, IDX_NEW);
        cand[2].row      = s1_row_reg;
        cand[2].col      = s1_col_reg - 1'b1;
        cand[3].lbp_code = lbp_pattern(win_next, top_cur, IDX_NEW, IDX_NEW,
                                       left_cur, IDX_NEW, IDX_NEW);
        cand[3].row      = s1_row_reg;
        cand[3].col      = s1_col_reg;

        cand_en[0] = (s1_row_reg != '0) && (s1_col_reg != '0);
        cand_en[1] = (s1_row_reg != '0) && s1_row_end_reg;
        cand_en[2] = s1_last_row_reg && (s1_col_reg != '0);
        cand_en[3] = s1_last_row_reg && s1_row_end_reg;
    end

    // Pack the enabled candidates in order.
    always_comb
    begin
        slot_next = cand;
        slot_cnt  = '0;
        for (int k = 0; k < MAX_RESULTS; k++)
        begin
            if (cand_en[k])
            begin
                slot_next[slot_cnt[RES_IDX_W-1:0]] = cand[k];
                slot_cnt = slot_cnt + 1'b1;
            end
        end
    end

    // Result register: loaded from the compare stage, drained one code per transaction.
    always_comb
    begin
        res_left_next = res_left_reg;
        res_ptr_next  = res_ptr_reg;
        if (s1_adv)
        begin
            res_left_next = slot_cnt;
            res_ptr_next  = '0;
        end
        else if (out_fire)
        begin
            res_left_next = res_left_reg - 1'b1;
            res_ptr_next  = res_ptr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_left_reg <= '0;
            res_ptr_reg  <= '0;
        end
        else
        begin
            res_left_reg <= res_left_next;
            res_ptr_reg  <= res_ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
            slot_reg <= slot_next;
    end

    // Output channel.
    assign res_out.valid       = (res_left_reg != '0);
    assign res_out.lbp_code    = slot_reg[res_ptr_reg].lbp_code;
    assign res_out.out_row     = slot_reg[res_ptr_reg].row;
    assign res_out.out_col     = slot_reg[res_ptr_reg].col;
    assign res_out.last_of_run = (res_left_reg == RES_CNT_W'(1));

`ifndef NO_ASSERTIONS
    // The result register never holds more codes than one pixel can release.
    a_res_bound: assert property (@(posedge clk) disable iff (!rst_n)
        res_left_reg <= RES_CNT_W'(MAX_RESULTS))
        else $error("result count exceeds the per-pixel maximum");

    // After the final code of a run is taken, the register is empty unless it was reloaded.
    a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
        (out_fire && res_out.last_of_run) |=> (res_left_reg == '0) || $past(s1_adv))
        else $error("codes left over after the last of a run");

    // Forwarded line data only exists for a pixel held in the read stage.
    a_fwd_owner: assert property (@(posedge clk) disable iff (!rst_n)
        fwd_valid_reg |-> s1_valid_reg)
        else $error("line forwarding without a pixel in the read stage");

    // A pixel is only taken when the read stage is empty or handing over.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |-> (!s1_valid_reg || s1_adv))
        else $error("read stage overwritten before it advanced");
`endif

endmodule

[rtl/core/lbp_ram.sv]
// Generic simple dual-port RAM: one write port, one read port with registered read data.
// No dependencies; contents are undefined until written.
module lbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // A read at the address being written returns the old contents.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
